// ===== design/dsat_pkg.sv =====
// Shared types, codes and field widths of the drain step arbiter with timers.
package dsat_pkg;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned ROOT_W     = 4;
  localparam int unsigned CLK_IDX_W  = 2;
  localparam int unsigned TIME_W     = 64;
  localparam int unsigned SERVED_W   = 3;
  localparam int unsigned FIRED_W    = 3;
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 80;

  typedef enum logic [CMD_W-1:0] {
    CMD_POKE_ROOT    = 3'd0,
    CMD_POKE_MAIN    = 3'd1,
    CMD_POKE_MANAGER = 3'd2,
    CMD_ARM_TIMER    = 3'd3,
    CMD_DEL_TIMER    = 3'd4,
    CMD_DRAIN_STEP   = 3'd5
  } cmd_e;

  typedef enum logic [SERVED_W-1:0] {
    SERVED_NONE    = 3'd0,
    SERVED_TIMERS  = 3'd1,
    SERVED_MANAGER = 3'd2,
    SERVED_MAIN    = 3'd3,
    SERVED_ROOT    = 3'd4
  } served_e;

endpackage

// ===== design/drain_step_arbiter_with_timers.sv =====
// Top level of the drain step arbiter with timers.
// A request accepted into the input register moves on to the result register,
// from which the output port presents its result.
// Throughput: one request per cycle while the result register is empty or its
// result is taken; the input and result registers form a two-stage pipeline.
// The state update of a request happens in the same edge that loads its result.
// Reset (rst_ni low, asynchronous) clears all pending bits, disarms every clock,
// zeroes the deadlines and points the rotation at the highest root.
module drain_step_arbiter_with_timers import dsat_pkg::*; #(
  parameter int unsigned NUM_ROOTS  = 12,
  parameter int unsigned NUM_CLOCKS = 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0 up: root_index[3:0], clock_index[5:4], delay[69:6],
  // now[133:70], heap_dirty[134], repoke_served[135].
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Fields from bit 0 up: command[2:0].
  input  logic [CMD_W-1:0]      s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0 up: served[2:0], served_root[6:3], fired_clocks[9:7],
  // work_done[10], next_deadline[74:11], bad_index[75], zero fill[79:76].
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // Input register stage.
  logic                 s1_valid_q;
  logic [CMD_W-1:0]     s1_cmd_q;
  logic [ROOT_W-1:0]    s1_ridx_q;
  logic [CLK_IDX_W-1:0] s1_cidx_q;
  logic [TIME_W-1:0]    s1_delay_q;
  logic [TIME_W-1:0]    s1_now_q;
  logic                 s1_dirty_q;
  logic                 s1_repoke_q;

  // Scheduler state.
  logic [NUM_ROOTS-1:0]  root_pend_q, root_pend_d;
  logic [ROOT_W-1:0]     rot_ptr_q, rot_ptr_d;
  logic                  main_pend_q, main_pend_d;
  logic                  mgr_pend_q, mgr_pend_d;
  logic [TIME_W-1:0]     deadline_q [NUM_CLOCKS];
  logic [TIME_W-1:0]     deadline_d [NUM_CLOCKS];
  logic [NUM_CLOCKS-1:0] armed_q, armed_d;

  // Result register stage. The earliest deadline is not stored: the state
  // only changes in the edge that loads a new result, so it is computed from
  // the state registers while the result is held.
  logic                  out_valid_q;
  logic [SERVED_W-1:0]   out_served_q, out_served_d;
  logic [ROOT_W-1:0]     out_root_q, out_root_d;
  logic [FIRED_W-1:0]    out_fired_q, out_fired_d;
  logic                  out_bad_q, out_bad_d;
  logic [TIME_W-1:0]     earliest;

  logic                  advance;
  logic                  upd;
  cmd_e                  cmd;
  logic [TIME_W-1:0]     arm_deadline;
  logic [NUM_CLOCKS-1:0] fired;
  logic [NUM_CLOCKS+FIRED_W-1:0] fired_ext;
  logic                  hit_lo, hit_any, others;
  logic [ROOT_W-1:0]     sel_lo, sel_any, sel;

  // The pipeline moves whenever the result register is free or being taken.
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || advance;
  assign upd           = s1_valid_q && advance;
  assign cmd           = cmd_e'(s1_cmd_q);
  assign arm_deadline  = s1_delay_q + s1_now_q;

  // Due clocks on a drain step: armed with a deadline at or below the current time.
  always_comb begin
    for (int k = 0; k < NUM_CLOCKS; k++) begin
      fired[k] = (cmd == CMD_DRAIN_STEP) && armed_q[k] && (deadline_q[k] <= s1_now_q);
    end
  end
  assign fired_ext = {{FIRED_W{1'b0}}, fired};

  // Downward round robin: the highest pending root at or below the pointer
  // wins; if there is none, the scan wraps and the highest pending root wins.
  always_comb begin
    hit_lo  = 1'b0;
    hit_any = 1'b0;
    sel_lo  = '0;
    sel_any = '0;
    others  = 1'b0;
    for (int i = 0; i < NUM_ROOTS; i++) begin
      if (root_pend_q[i]) begin
        hit_any = 1'b1;
        sel_any = ROOT_W'(i);
        if (ROOT_W'(i) <= rot_ptr_q) begin
          hit_lo = 1'b1;
          sel_lo = ROOT_W'(i);
        end
      end
    end
    sel = hit_lo ? sel_lo : sel_any;
    for (int i = 0; i < NUM_ROOTS; i++) begin
      if (root_pend_q[i] && (ROOT_W'(i) != sel)) begin
        others = 1'b1;
      end
    end
  end

  // Next state and result of the request in the input register.
  always_comb begin
    root_pend_d  = root_pend_q;
    rot_ptr_d    = rot_ptr_q;
    main_pend_d  = main_pend_q;
    mgr_pend_d   = mgr_pend_q;
    armed_d      = armed_q;
    deadline_d   = deadline_q;
    out_served_d = SERVED_NONE;
    out_root_d   = '0;
    out_fired_d  = fired_ext[FIRED_W-1:0];
    out_bad_d    = 1'b0;
    case (cmd)
      CMD_POKE_ROOT: begin
        // Indices at or above the root count match no entry and are flagged.
        out_bad_d = 1'b1;
        for (int i = 0; i < NUM_ROOTS; i++) begin
          if (s1_ridx_q == ROOT_W'(i)) begin
            root_pend_d[i] = 1'b1;
            out_bad_d      = 1'b0;
          end
        end
      end
      CMD_POKE_MAIN: begin
        main_pend_d = 1'b1;
      end
      CMD_POKE_MANAGER: begin
        mgr_pend_d = 1'b1;
      end
      CMD_ARM_TIMER: begin
        for (int k = 0; k < NUM_CLOCKS; k++) begin
          if (int'(s1_cidx_q) == k) begin
            deadline_d[k] = arm_deadline;
            armed_d[k]    = 1'b1;
          end
        end
      end
      CMD_DEL_TIMER: begin
        for (int k = 0; k < NUM_CLOCKS; k++) begin
          if (int'(s1_cidx_q) == k) begin
            armed_d[k] = 1'b0;
          end
        end
      end
      CMD_DRAIN_STEP: begin
        armed_d = armed_q & ~fired;
        if ((|fired) || s1_dirty_q) begin
          out_served_d = SERVED_TIMERS;
        end else if (mgr_pend_q) begin
          mgr_pend_d   = 1'b0;
          out_served_d = SERVED_MANAGER;
        end else if (main_pend_q) begin
          main_pend_d  = 1'b0;
          out_served_d = SERVED_MAIN;
        end else if (hit_any) begin
          out_served_d = SERVED_ROOT;
          out_root_d   = sel;
          for (int i = 0; i < NUM_ROOTS; i++) begin
            if (ROOT_W'(i) == sel) begin
              root_pend_d[i] = s1_repoke_q;
            end
          end
          // The pointer moves just below the served root while work remains, unless root 0 was served.
          if ((others || s1_repoke_q) && (sel != '0)) begin
            rot_ptr_d = sel - ROOT_W'(1);
          end else begin
            rot_ptr_d = ROOT_W'(NUM_ROOTS - 1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Earliest armed nonzero deadline; zero stands for none.
  always_comb begin
    earliest = '0;
    for (int k = 0; k < NUM_CLOCKS; k++) begin
      if (armed_q[k] && (deadline_q[k] != '0) &&
          ((earliest == '0) || (deadline_q[k] < earliest))) begin
        earliest = deadline_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      root_pend_q <= '0;
      rot_ptr_q   <= ROOT_W'(NUM_ROOTS - 1);
      main_pend_q <= 1'b0;
      mgr_pend_q  <= 1'b0;
      armed_q     <= '0;
      for (int k = 0; k < NUM_CLOCKS; k++) begin
        deadline_q[k] <= '0;
      end
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
      if (upd) begin
        root_pend_q <= root_pend_d;
        rot_ptr_q   <= rot_ptr_d;
        main_pend_q <= main_pend_d;
        mgr_pend_q  <= mgr_pend_d;
        armed_q     <= armed_d;
        deadline_q  <= deadline_d;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_cmd_q    <= s_axis_tuser;
      s1_ridx_q   <= s_axis_tdata[3:0];
      s1_cidx_q   <= s_axis_tdata[5:4];
      s1_delay_q  <= s_axis_tdata[69:6];
      s1_now_q    <= s_axis_tdata[133:70];
      s1_dirty_q  <= s_axis_tdata[134];
      s1_repoke_q <= s_axis_tdata[135];
    end
    if (upd) begin
      out_served_q <= out_served_d;
      out_root_q   <= out_root_d;
      out_fired_q  <= out_fired_d;
      out_bad_q    <= out_bad_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_bad_q, earliest,
                          (out_served_q != SERVED_NONE),
                          out_fired_q, out_root_q, out_served_q};

endmodule

// ===== design/dsat_checker.sv =====
// Port-level checker for the drain step arbiter with timers, and its bind.
module dsat_checker import dsat_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic [SERVED_W-1:0] served;
  assign served = m_axis_tdata[2:0];

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[10] == (served != SERVED_NONE)))
    else $error("work_done disagrees with served");

  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (served != SERVED_ROOT) |-> (m_axis_tdata[6:3] == '0))
    else $error("served_root set without a root being served");

  // Fired clocks always force timer service in the same step.
  a_fired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[9:7] != '0) |-> (served == SERVED_TIMERS))
    else $error("clocks fired without timer service");

  a_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[75] |-> (served == SERVED_NONE) &&
                                           (m_axis_tdata[9:7] == '0))
    else $error("bad index reported on a drain step");

endmodule

bind drain_step_arbiter_with_timers dsat_checker u_dsat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
